### hw/rtl/sem_pkg.sv
// Shared constants and types for the Sobel edge magnitude block.
package sem_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int PIX_BITS       = 8;
  localparam int FW_BITS        = 11;
  localparam int FH_BITS        = 16;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 1;

  localparam logic [FW_BITS-1:0] FW_RESET = FW_BITS'(640);
  localparam logic [FH_BITS-1:0] FH_RESET = FH_BITS'(480);

  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 1'd1;

  typedef struct packed {
    logic                valid;
    logic                last;
    logic [PIX_BITS-1:0] ma;
    logic [PIX_BITS-1:0] mb;
  } grad_t;

endpackage

### hw/rtl/sem_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module sem_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/sem_front.sv
// Position counters, line store access, 3x3 window and clamped gradients.
module sem_front
  import sem_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                accept,
  input  logic                kind,
  input  logic [PIX_BITS-1:0] red,
  input  logic [FW_BITS-1:0]  frame_width,
  input  logic [FH_BITS-1:0]  frame_height,
  output grad_t               grad
);

  localparam int COLW  = $clog2(MAX_WIDTH);
  localparam int WBITS = $clog2(MAX_WIDTH + 1);
  localparam int EW    = (WBITS > FW_BITS) ? WBITS : FW_BITS;
  localparam int LW    = 2 * PIX_BITS;

  // counters
  logic [COLW-1:0]    in_column;
  logic [1:0]         in_rows;
  logic [COLW-1:0]    out_column;
  logic [FH_BITS-1:0] out_row;

  // stage 1
  logic                s1_valid;
  logic                s1_emit;
  logic                s1_last;
  logic                s1_restart;
  logic                s1_shift;
  logic                s1_left;
  logic                s1_right;
  logic                s1_top;
  logic                s1_bot;
  logic [PIX_BITS-1:0] s1_v;
  logic [COLW-1:0]     s1_addr;
  logic                s1_fwd;
  logic [LW-1:0]       s1_fwd_data;

  logic [PIX_BITS-1:0] win [3][3];

  logic [EW-1:0]      eff_w;
  logic [FH_BITS-1:0] eff_h;
  logic [EW-1:0]      in_col_inc;
  logic [EW-1:0]      out_col_inc;
  logic [FH_BITS:0]   out_row_inc;
  logic               col_wrap;
  logic               ocol_wrap;
  logic               ready;
  logic               row_over;
  logic               emit;
  logic               is_last;
  logic               restart;
  logic [PIX_BITS-1:0] sample;

  logic [LW-1:0]       ram_q;
  logic [LW-1:0]       rd_word;
  logic [PIX_BITS-1:0] col [3];
  logic [LW-1:0]       wr_word;
  logic                wr_en;

  logic [PIX_BITS-1:0] win_sh [3][3];
  logic [PIX_BITS-1:0] p      [3][3];
  logic [11:0]         a_sum;
  logic [11:0]         b_sum;
  logic [PIX_BITS-1:0] ma;
  logic [PIX_BITS-1:0] mb;

  always_comb begin
    if (frame_width == '0) begin
      eff_w = EW'(1);
    end else if (EW'(frame_width) > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(frame_width);
    end
    eff_h = (frame_height == '0) ? FH_BITS'(1) : frame_height;

    in_col_inc  = EW'(in_column) + EW'(1);
    out_col_inc = EW'(out_column) + EW'(1);
    out_row_inc = {1'b0, out_row} + (FH_BITS+1)'(1);
    col_wrap    = in_col_inc >= eff_w;
    ocol_wrap   = out_col_inc >= eff_w;

    ready    = (in_column != '0) ? (in_rows != 2'd0) : (in_rows == 2'd2);
    row_over = out_row >= eff_h;
    emit     = ready && !row_over;
    is_last  = emit && (out_row_inc == {1'b0, eff_h}) && ocol_wrap;
    restart  = ready && (row_over || is_last);
    sample   = kind ? '0 : red;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      in_rows    <= 2'd0;
      out_column <= '0;
      out_row    <= '0;
    end else if (accept) begin
      if (restart) begin
        in_column  <= '0;
        in_rows    <= 2'd0;
        out_column <= '0;
        out_row    <= '0;
      end else begin
        if (col_wrap) begin
          in_column <= '0;
          if (in_rows != 2'd2) begin
            in_rows <= in_rows + 2'd1;
          end
        end else begin
          in_column <= in_col_inc[COLW-1:0];
        end
        if (emit) begin
          if (ocol_wrap) begin
            out_column <= '0;
            out_row    <= out_row_inc[FH_BITS-1:0];
          end else begin
            out_column <= out_col_inc[COLW-1:0];
          end
        end
      end
    end
  end

  // line stores: {two rows above, one row above} per column
  sem_ram #(
    .WIDTH(LW),
    .DEPTH(MAX_WIDTH)
  ) u_lines (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(s1_addr),
    .wr_data(wr_word),
    .rd_en  (accept),
    .rd_addr(in_column),
    .rd_data(ram_q)
  );

  always_comb begin
    rd_word = s1_fwd ? s1_fwd_data : ram_q;
    col[0]  = rd_word[LW-1:PIX_BITS];
    col[1]  = rd_word[PIX_BITS-1:0];
    col[2]  = s1_v;
    wr_word = {col[1], s1_v};
    wr_en   = s1_valid && en;

    for (int r = 0; r < 3; r++) begin
      win_sh[r][0] = win[r][1];
      win_sh[r][1] = win[r][2];
      win_sh[r][2] = col[r];
    end

    for (int r = 0; r < 3; r++) begin
      if (s1_shift) begin
        p[r][0] = win_sh[r][0];
        p[r][1] = win_sh[r][1];
        p[r][2] = win_sh[r][2];
      end else begin
        p[r][0] = win[r][1];
        p[r][1] = win[r][2];
        p[r][2] = '0;
      end
    end

    for (int r = 0; r < 3; r++) begin
      if (s1_left)  p[r][0] = '0;
      if (s1_right) p[r][2] = '0;
    end
    for (int c = 0; c < 3; c++) begin
      if (s1_top) p[0][c] = '0;
      if (s1_bot) p[2][c] = '0;
    end

    a_sum = 12'(p[2][0]) - 12'(p[0][0])
          + ((12'(p[2][1]) - 12'(p[0][1])) << 1)
          + 12'(p[2][2]) - 12'(p[0][2]);
    b_sum = 12'(p[0][0]) - 12'(p[0][2])
          + ((12'(p[1][0]) - 12'(p[1][2])) << 1)
          + 12'(p[2][0]) - 12'(p[2][2]);

    if (a_sum[11]) begin
      ma = '0;
    end else if (a_sum[10:8] != 3'd0) begin
      ma = '1;
    end else begin
      ma = a_sum[7:0];
    end
    if (b_sum[11]) begin
      mb = '0;
    end else if (b_sum[10:8] != 3'd0) begin
      mb = '1;
    end else begin
      mb = b_sum[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_emit     <= emit;
      s1_last     <= is_last;
      s1_restart  <= restart;
      s1_shift    <= in_column != '0;
      s1_left     <= out_column == '0;
      s1_right    <= ocol_wrap;
      s1_top      <= out_row == '0;
      s1_bot      <= out_row_inc >= {1'b0, eff_h};
      s1_v        <= sample;
      s1_addr     <= in_column;
      // stage 1 writes this column in the same cycle as the read
      s1_fwd      <= s1_valid && (s1_addr == in_column);
      s1_fwd_data <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (s1_valid && en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= s1_restart ? '0 : win_sh[r][c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grad <= '0;
    end else if (en) begin
      grad.valid <= s1_valid && s1_emit;
      grad.last  <= s1_last;
      grad.ma    <= ma;
      grad.mb    <= mb;
    end
  end

endmodule

### hw/rtl/sem_magnitude.sv
// Sum of squares and pipelined integer square root, two root bits per stage.
module sem_magnitude
  import sem_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  grad_t               grad,
  output logic                valid,
  output logic [PIX_BITS-1:0] magnitude,
  output logic                last
);

  localparam int NSTAGE = 4;
  localparam int SQW    = 2 * PIX_BITS;

  logic             valid_q [NSTAGE+1];
  logic             last_q  [NSTAGE+1];
  logic             sat_q   [NSTAGE+1];
  logic [SQW-1:0]   op_q    [NSTAGE+1];
  logic [SQW-1:0]   res_q   [NSTAGE+1];

  logic [SQW-1:0]   sq_a;
  logic [SQW-1:0]   sq_b;
  logic [SQW:0]     sq_sum;

  assign sq_a   = SQW'(grad.ma) * SQW'(grad.ma);
  assign sq_b   = SQW'(grad.mb) * SQW'(grad.mb);
  assign sq_sum = {1'b0, sq_a} + {1'b0, sq_b};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q[0] <= 1'b0;
    end else if (en) begin
      valid_q[0] <= grad.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      last_q[0] <= grad.last;
      sat_q[0]  <= sq_sum[SQW];
      op_q[0]   <= sq_sum[SQW-1:0];
      res_q[0]  <= '0;
    end
  end

  for (genvar k = 0; k < NSTAGE; k++) begin : g_stage
    logic [SQW-1:0] op_n;
    logic [SQW-1:0] res_n;
    logic [SQW:0]   trial;
    logic [SQW-1:0] one;

    always_comb begin
      op_n  = op_q[k];
      res_n = res_q[k];
      trial = '0;
      one   = '0;
      for (int j = 0; j < 2; j++) begin
        one   = SQW'(1) << (SQW - 2 - 4 * k - 2 * j);
        trial = {1'b0, res_n} + {1'b0, one};
        if ({1'b0, op_n} >= trial) begin
          op_n  = op_n - trial[SQW-1:0];
          res_n = (res_n >> 1) + one;
        end else begin
          res_n = res_n >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[k+1] <= 1'b0;
      end else if (en) begin
        valid_q[k+1] <= valid_q[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        last_q[k+1] <= last_q[k];
        sat_q[k+1]  <= sat_q[k];
        op_q[k+1]   <= op_n;
        res_q[k+1]  <= res_n;
      end
    end
  end

  assign valid     = valid_q[NSTAGE];
  assign last      = last_q[NSTAGE];
  assign magnitude = sat_q[NSTAGE] ? '1 : res_q[NSTAGE][PIX_BITS-1:0];

endmodule

### hw/rtl/sobel_edge_magnitude_top.sv
// A result passes stage 1, gradient, square-sum and root registers after the item that
// completes it, W+1 places after its pixel, is transferred. Throughput: one item per
// cycle; a stalled result freezes the whole pipeline. The single line store RAM is read
// and written once per item, with same-column forwarding. Reset clears counters, window
// and pipeline valids, and sets width 640, height 480; the line stores are not cleared.
module sobel_edge_magnitude_top
  import sem_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      pixel_valid,
  output logic                      pixel_stall,
  input  logic                      kind,
  input  logic [PIX_BITS-1:0]       red,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic [PIX_BITS-1:0]       magnitude,
  output logic                      last,
  input  logic                      config_write,
  input  logic [CFG_INDEX_BITS-1:0] config_index,
  input  logic [CFG_DATA_BITS-1:0]  config_data
);

  logic [FW_BITS-1:0] frame_width;
  logic [FH_BITS-1:0] frame_height;
  logic               adv;
  logic               accept;
  grad_t              grad;

  assign adv         = !result_valid || !result_stall;
  assign pixel_stall = !adv;
  assign accept      = pixel_valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FW_RESET;
      frame_height <= FH_RESET;
    end else if (config_write) begin
      unique case (config_index)
        REG_FRAME_WIDTH:  frame_width  <= config_data[FW_BITS-1:0];
        REG_FRAME_HEIGHT: frame_height <= config_data[FH_BITS-1:0];
        default: ;
      endcase
    end
  end

  sem_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .en          (adv),
    .accept      (accept),
    .kind        (kind),
    .red         (red),
    .frame_width (frame_width),
    .frame_height(frame_height),
    .grad        (grad)
  );

  sem_magnitude u_magnitude (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .grad     (grad),
    .valid    (result_valid),
    .magnitude(magnitude),
    .last     (last)
  );

endmodule
